FILE: rtl/ple_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int CAPACITY    = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int LEN_W       = 5;
    localparam int POS_W       = 8;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_END   = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_END   = 3'd4;
    localparam logic [2:0] CMD_DEL_POS   = 3'd5;
    localparam logic [2:0] CMD_LIST      = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BOUNDS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]        command;
        logic signed [31:0] item_in;
        logic [POS_W-1:0]  position;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item_out;
        logic [LEN_W-1:0]   list_length;
        logic               last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_LIST
    } op_kind_t;

    typedef enum logic [1:0] {
        AT_FRONT,
        AT_END,
        AT_POS
    } op_where_t;

    // Classified command as it sits in the queue.
    typedef struct packed {
        op_kind_t         kind;
        op_where_t        where;
        logic [31:0]      value;
        logic [POS_W-1:0] pos;
    } op_t;

endpackage

FILE: rtl/ple_front.sv
`timescale 1ns / 1ps
// Front end: accepts command items and classifies them for the queue.
module ple_front (
    input  ple_pkg::cmd_item_t cmd_item,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic               q_full,
    output logic               push,
    output ple_pkg::op_t       push_op
);
    import ple_pkg::*;

    logic keep;

    assign cmd_stall = q_full;

    always_comb
    begin
        keep           = 1'b1;
        push_op.kind   = OP_INSERT;
        push_op.where  = AT_FRONT;
        push_op.value  = cmd_item.item_in;
        push_op.pos    = cmd_item.position;
        unique case (cmd_item.command) inside
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS:
                push_op.kind = OP_INSERT;
            CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS:
                push_op.kind = OP_DELETE;
            CMD_LIST:
                push_op.kind = OP_LIST;
            default:
                keep = 1'b0;   // unused code: dropped, no result
        endcase
        unique case (cmd_item.command) inside
            CMD_INS_END, CMD_DEL_END:
                push_op.where = AT_END;
            CMD_INS_POS, CMD_DEL_POS:
                push_op.where = AT_POS;
            default:
                push_op.where = AT_FRONT;
        endcase
    end

    assign push = cmd_valid && !q_full && keep;

endmodule

FILE: rtl/ple_queue.sv
`timescale 1ns / 1ps
// Short queue of classified commands between front and back end.
module ple_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ple_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output ple_pkg::op_t head_op
);
    import ple_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: rtl/ple_back.sv
`timescale 1ns / 1ps
// Back end: element cells, list count, command execution and result register.
module ple_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  ple_pkg::op_t       head_op,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ple_pkg::rsp_item_t rsp_item
);
    import ple_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    rsp_item_t        out_reg, out_next;

    logic [31:0]      cell_reg [CAPACITY];
    logic [31:0]      cell_next [CAPACITY];

    logic             out_free;
    logic             do_ins, do_del;
    logic [IDX_W-1:0] ins_idx, del_idx;
    logic [8:0]       pos_ext, cnt_ext;
    logic             pos_zero, list_end;
    logic [1:0]       st;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    assign pos_ext  = {1'b0, head_op.pos};
    assign cnt_ext  = 9'(count_reg);
    assign pos_zero = (head_op.pos == '0);
    assign list_end = (CNT_W'(idx_reg) + 1'b1 == count_reg);

    always_comb
    begin
        unique case (head_op.where)
            AT_FRONT: ins_idx = '0;
            AT_END:   ins_idx = count_reg[IDX_W-1:0];
            default:  ins_idx = IDX_W'(head_op.pos - 1'b1);
        endcase
        unique case (head_op.where)
            AT_FRONT: del_idx = '0;
            AT_END:   del_idx = IDX_W'(count_reg - 1'b1);
            default:  del_idx = IDX_W'(head_op.pos - 1'b1);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        pop            = 1'b0;
        do_ins         = 1'b0;
        do_del         = 1'b0;
        st             = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    case (head_op.kind)
                        OP_INSERT:
                        begin
                            // bounds check wins over full check
                            if (head_op.where == AT_POS && (pos_zero || pos_ext > cnt_ext + 1'b1))
                            begin
                                st = ST_BOUNDS;
                            end
                            else if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                st = ST_FULL;
                            end
                            else
                            begin
                                do_ins     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                st = ST_EMPTY;
                            end
                            else if (head_op.where == AT_POS && (pos_zero || pos_ext > cnt_ext))
                            begin
                                st = ST_BOUNDS;
                            end
                            else
                            begin
                                do_del     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                st = ST_EMPTY;
                            end
                        end
                    endcase
                    if (head_op.kind == OP_LIST && count_reg != '0)
                    begin
                        state_next = S_LIST;
                        idx_next   = '0;
                    end
                    else
                    begin
                        out_valid_next       = 1'b1;
                        out_next.status      = st;
                        out_next.item_out    = '0;
                        out_next.list_length = LEN_W'(count_next);
                        out_next.last        = 1'b1;
                    end
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = ST_OK;
                    out_next.item_out    = cell_reg[idx_reg];
                    out_next.list_length = LEN_W'(count_reg);
                    out_next.last        = list_end;
                    if (list_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    // Each cell picks hold, new value, or its neighbor for the shift.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [31:0] below, above;
        if (g == 0)
        begin : g_first
            assign below = cell_reg[0];
        end
        else
        begin : g_rest
            assign below = cell_reg[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_lastc
            assign above = cell_reg[g];
        end
        else
        begin : g_mid
            assign above = cell_reg[g+1];
        end
        always_comb
        begin
            cell_next[g] = cell_reg[g];
            if (do_ins && IDX_W'(g) == ins_idx)
            begin
                cell_next[g] = head_op.value;
            end
            else if (do_ins && IDX_W'(g) > ins_idx)
            begin
                cell_next[g] = below;
            end
            else if (do_del && IDX_W'(g) >= del_idx)
            begin
                cell_next[g] = above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_list_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |-> CNT_W'(idx_reg) < count_reg)
        else $error("listing index past end of list");

    a_not_last_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last |-> state_reg == S_LIST)
        else $error("non-final result held outside a listing");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK |-> out_reg.last && out_reg.item_out == '0)
        else $error("status result with payload or without last mark");

    a_count_steady_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |=> $stable(count_reg))
        else $error("list count changed during a listing");

endmodule

FILE: rtl/positional_list_engine_core.sv
`timescale 1ns / 1ps
// Top level of the positional list engine.
//
//  channel  dir  handshake          payload
//  cmd      in   cmd_valid/stall    cmd_item  (command, item_in, position)
//  rsp      out  rsp_valid/stall    rsp_item  (status, item_out, list_length, last)
//
// Insert and delete run in the back end with all cells shifting at once.
// A listing reads the elements out in order through the single read port on
// the cell row, and the back end takes no new command until the listing ends.
// The command queue registers each command and lets cmd run ahead of rsp.
// Reset empties the list and queue; element cells are not cleared.
module positional_list_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ple_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ple_pkg::rsp_item_t rsp_item
);
    import ple_pkg::*;

    logic q_full, push, pop, head_valid;
    op_t  push_op, head_op;

    ple_front u_front (
        .cmd_item  (cmd_item),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op)
    );

    ple_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    ple_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item)
    );

endmodule
